// ===== rtl/brexg_pkg.sv =====
// Shared types and constants of the Exp-Golomb bit reader.
`timescale 1ns / 1ps
`default_nettype none

package brexg_pkg;

  // Default byte store depth
  localparam int unsigned BUF_BYTES_DEF = 4096;

  // Widest field that get, peek and the code body may read
  localparam int unsigned MAX_BITS = 32;

  // Bytes gathered for one field read: a 32-bit field at any bit offset spans five bytes
  localparam int unsigned WIN_BYTES = MAX_BITS / 8 + 1;
  localparam int unsigned WIN_W = WIN_BYTES * 8;

  // Value returned by a failed ue decode
  localparam logic [MAX_BITS-1:0] UE_FAIL = '1;

  // Command codes
  typedef enum logic [2:0] {
    OP_RESTART = 3'd0,
    OP_LOAD    = 3'd1,
    OP_GET     = 3'd2,
    OP_PEEK    = 3'd3,
    OP_UE      = 3'd4,
    OP_SE      = 3'd5,
    OP_SEEK    = 3'd6
  } brexg_op_e;

  // Control from the sequencer to the read window
  typedef struct packed {
    logic       shift;  // take the store's read byte into the window
    logic [2:0] off;    // bit offset of the field within the first byte
    logic [5:0] cnt;    // field length in bits, 0 to 32
  } brexg_win_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/brexg_store.sv =====
// Byte store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module brexg_store
  import brexg_pkg::*;
#(
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF,
  localparam int unsigned AW = $clog2(BUF_BYTES)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [BUF_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/brexg_window.sv =====
// Read window: gathers five stream bytes and extracts an MSB-first field.
`timescale 1ns / 1ps
`default_nettype none

module brexg_window
  import brexg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire brexg_win_ctrl_t       ctrl_i,
  input  wire logic [7:0]            byte_i,
  output logic      [MAX_BITS-1:0]   value_o
);

  logic [WIN_W-1:0]    win_q;
  logic [WIN_W-1:0]    aligned;
  logic [MAX_BITS-1:0] top_bits;

  // Shift bytes in from the bottom; the oldest byte ends up on top
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      win_q <= {win_q[WIN_W-9:0], byte_i};
    end
  end

  // Drop the bits before the field, then right-justify cnt bits
  always_comb begin
    aligned  = win_q << ctrl_i.off;
    top_bits = aligned[WIN_W-1 -: MAX_BITS];
    value_o  = top_bits >> (6'(MAX_BITS) - ctrl_i.cnt);
  end

endmodule

`default_nettype wire

// ===== rtl/bit_reader_exp_golomb.sv =====
// Top level of the Exp-Golomb bit reader: command sequencer, position and length state.
`timescale 1ns / 1ps
`default_nettype none

// Bit reader over a byte buffer of BUF_BYTES entries. Each input word carries one
// command (restart, load byte, get, peek, ue, se, seek) and gives exactly one output
// word with the value, an error flag and the loaded bits left past the current
// position (modulo 2^16). Commands run one at a time; the input takes a new word once
// the previous result sits in the output register, so a waiting result does not hold
// off the next command. Restart, load, seek and any rejected get or peek go straight
// from acceptance to the result state. Get and peek gather five bytes through the
// store's single read port, one byte a cycle, with registered read data. A ue or se
// first scans for the leading one bit a byte a cycle, then reads the code body the
// same way as get; the scan reads every zero byte before the byte that holds the
// leading one bit. The store needs no clearing after reset; only bytes
// loaded since the last restart are read.
module bit_reader_exp_golomb
  import brexg_pkg::*;
#(
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[2:0], data_byte[10:3], bit_count[16:11], seek_position[32:17], zero fill
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // value[31:0], error[32], bits_remaining[48:33], zero fill
  output logic      [55:0] m_axis_tdata
);

  localparam int unsigned LEN_W = $clog2(BUF_BYTES + 1);  // byte count, 0..BUF_BYTES
  localparam int unsigned AW    = $clog2(BUF_BYTES);      // store address
  localparam int unsigned PW    = LEN_W + 3;              // bit position
  localparam int unsigned SAW   = LEN_W + 1;              // scan byte address
  localparam int unsigned CW    = (PW > 16) ? PW : 16;    // position arithmetic

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_FIN
  } state_e;

  // Leading zeros of a nonzero byte, MSB first
  function automatic logic [2:0] lead_zeros(input logic [7:0] b);
    logic [2:0] lz;
    logic       found;
    lz    = '0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && b[7-i]) begin
        lz    = 3'(i);
        found = 1'b1;
      end
    end
    return lz;
  endfunction

  // Input word fields
  brexg_op_e   in_op;
  logic [7:0]  in_byte;
  logic [5:0]  in_cnt;
  logic [15:0] in_seek;

  assign in_op   = brexg_op_e'(s_axis_tdata[2:0]);
  assign in_byte = s_axis_tdata[10:3];
  assign in_cnt  = s_axis_tdata[16:11];
  assign in_seek = s_axis_tdata[32:17];

  // State
  state_e              state_q, state_d;
  brexg_op_e           op_q, op_d;
  logic [5:0]          cnt_q, cnt_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic [SAW-1:0]      sc_addr_q, sc_addr_d;
  logic [SAW-1:0]      sc_daddr_q, sc_daddr_d;
  logic                sc_vld_q, sc_vld_d;
  logic [2:0]          rd_cnt_q, rd_cnt_d;
  logic                rd_vld_q, rd_vld_d;
  logic [MAX_BITS-1:0] res_val_q, res_val_d;
  logic                res_err_q, res_err_d;
  logic                m_tvalid_q, m_tvalid_d;
  logic [55:0]         m_tdata_q, m_tdata_d;

  // Store and window hookup
  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [7:0]      mem_rdata;
  brexg_win_ctrl_t win_ctrl;
  logic [MAX_BITS-1:0] win_val;

  // Position arithmetic
  logic [CW-1:0]   total_w;
  logic [CW-1:0]   pos_w;
  logic [CW-1:0]   rem_w;
  logic            scan_first;
  logic [7:0]      scan_byte;
  logic [2:0]      scan_lz;
  logic [CW-1:0]   q_w;
  logic [CW-1:0]   zeros_w;
  logic [AW-1:0]   rd_base;
  logic [MAX_BITS-1:0] ue_val;
  logic [MAX_BITS-1:0] se_val;

  assign total_w = CW'({len_q, 3'b000});
  assign pos_w   = CW'(pos_q);
  assign rem_w   = total_w - pos_w;
  assign rd_base = AW'(pos_q[PW-1:3]);

  // Scan: mask the bits before the start position in the first byte
  assign scan_first = (sc_daddr_q == SAW'(pos_q[PW-1:3]));
  assign scan_byte  = mem_rdata & (scan_first ? (8'hFF >> pos_q[2:0]) : 8'hFF);
  assign scan_lz    = lead_zeros(scan_byte);
  assign q_w        = CW'({sc_daddr_q, 3'b000}) + CW'(scan_lz);
  assign zeros_w    = q_w - pos_w;

  // Code number and its signed mapping
  assign ue_val = win_val - 1'b1;
  assign se_val = ue_val[0] ? MAX_BITS'((({1'b0, ue_val}) + 1'b1) >> 1)
                            : ('0 - (ue_val >> 1));

  assign win_ctrl.shift = rd_vld_q;
  assign win_ctrl.off   = pos_q[2:0];
  assign win_ctrl.cnt   = cnt_q;

  brexg_store #(
    .BUF_BYTES (BUF_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (in_byte),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  brexg_window u_window (
    .clk_i   (clk_i),
    .ctrl_i  (win_ctrl),
    .byte_i  (mem_rdata),
    .value_o (win_val)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    pos_d      = pos_q;
    sc_addr_d  = sc_addr_q;
    sc_daddr_d = sc_daddr_q;
    sc_vld_d   = 1'b0;
    rd_cnt_d   = rd_cnt_q;
    rd_vld_d   = 1'b0;
    res_val_d  = res_val_q;
    res_err_d  = res_err_q;
    m_tdata_d  = m_tdata_q;
    // Drop the output word once it is taken
    m_tvalid_d = m_tvalid_q && !m_axis_tready;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = rd_base;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d      = in_op;
          cnt_d     = in_cnt;
          res_val_d = '0;
          res_err_d = 1'b0;
          state_d   = ST_FIN;
          unique case (in_op)
            OP_RESTART: begin
              len_d = '0;
              pos_d = '0;
            end
            OP_LOAD: begin
              if (len_q < LEN_W'(BUF_BYTES)) begin
                mem_we = 1'b1;
                len_d  = len_q + 1'b1;
              end else begin
                res_err_d = 1'b1;
              end
            end
            OP_GET, OP_PEEK: begin
              if (in_cnt > 6'(MAX_BITS) || CW'(in_cnt) > rem_w) begin
                res_err_d = 1'b1;
              end else begin
                rd_cnt_d = '0;
                state_d  = ST_READ;
              end
            end
            OP_UE, OP_SE: begin
              sc_addr_d = SAW'(pos_q[PW-1:3]);
              state_d   = ST_SCAN;
            end
            OP_SEEK: begin
              if (CW'(in_seek) <= total_w) begin
                pos_d = PW'(in_seek);
              end else begin
                res_err_d = 1'b1;
              end
            end
            default: begin
              // unused code: no state change, zero result
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (sc_vld_q && (sc_daddr_q >= SAW'(len_q))) begin
          // No one bit before the end: consume the whole zero bytes only
          pos_d     = PW'(total_w - CW'(rem_w[2:0]));
          res_val_d = (op_q == OP_UE) ? UE_FAIL : '0;
          res_err_d = 1'b1;
          state_d   = ST_FIN;
        end else if (sc_vld_q && (scan_byte != 8'h00)) begin
          // Leading zeros are consumed whether or not the code body fits
          pos_d = PW'(q_w);
          if (zeros_w > CW'(MAX_BITS - 1) || (zeros_w + 1'b1) > (total_w - q_w)) begin
            res_val_d = (op_q == OP_UE) ? UE_FAIL : '0;
            res_err_d = 1'b1;
            state_d   = ST_FIN;
          end else begin
            cnt_d    = 6'(zeros_w) + 1'b1;
            rd_cnt_d = '0;
            state_d  = ST_READ;
          end
        end else begin
          // Advance one byte a cycle
          mem_re     = 1'b1;
          mem_raddr  = sc_addr_q[AW-1:0];
          sc_addr_d  = sc_addr_q + 1'b1;
          sc_daddr_d = sc_addr_q;
          sc_vld_d   = 1'b1;
        end
      end

      ST_READ: begin
        if (rd_cnt_q != 3'(WIN_BYTES)) begin
          mem_re    = 1'b1;
          mem_raddr = rd_base + AW'(rd_cnt_q);
          rd_cnt_d  = rd_cnt_q + 1'b1;
          rd_vld_d  = 1'b1;
        end else if (!rd_vld_q) begin
          // Window full: hand over the field and advance unless peeking
          if (op_q != OP_PEEK) begin
            pos_d = PW'(pos_w + CW'(cnt_q));
          end
          unique case (op_q)
            OP_UE:   res_val_d = ue_val;
            OP_SE:   res_val_d = se_val;
            default: res_val_d = win_val;
          endcase
          res_err_d = 1'b0;
          state_d   = ST_FIN;
        end
      end

      ST_FIN: begin
        // Hold until the output register is free
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {7'b0, rem_w[15:0], res_err_q, res_val_q};
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      len_q      <= '0;
      pos_q      <= '0;
      sc_vld_q   <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_cnt_q   <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      pos_q      <= pos_d;
      sc_vld_q   <= sc_vld_d;
      rd_vld_q   <= rd_vld_d;
      rd_cnt_q   <= rd_cnt_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    cnt_q      <= cnt_d;
    sc_addr_q  <= sc_addr_d;
    sc_daddr_q <= sc_daddr_d;
    res_val_q  <= res_val_d;
    res_err_q  <= res_err_d;
    m_tdata_q  <= m_tdata_d;
  end

endmodule

`default_nettype wire

// ===== tb/bit_reader_exp_golomb_tb.sv =====
// Self-checking testbench of the Exp-Golomb bit reader: directed table and coded streams.
`timescale 1ns / 1ps

module bit_reader_exp_golomb_tb;
  import brexg_pkg::*;

  localparam int unsigned DEPTH        = BUF_BYTES_DEF;
  localparam int unsigned IDX_W        = $clog2(DEPTH);
  localparam int unsigned CODED_WORDS  = 1900;
  localparam int unsigned PLAN_ROWS    = 25;
  localparam int unsigned IDLE_PERCENT = 24;
  // Opcode with no command behind it: no state change, zero value, no error
  localparam logic [2:0]  OP_SPARE     = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data;
    logic [5:0]  count;
    logic [15:0] target;
  } cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic        error;
    logic [15:0] remaining;
  } reply_t;

  typedef struct packed {
    cmd_t   c;
    logic   typed;   // expected reply given below instead of predicted
    reply_t fixed;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // opcode[2:0], data_byte[10:3], bit_count[16:11], seek_position[32:17], zero fill
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // value[31:0], error[32], bits_remaining[48:33], zero fill
  logic [55:0] m_axis_tdata;

  // Shadow of the reader: byte store, bytes loaded, bit position
  logic [7:0]  mirror_bytes [DEPTH];
  int unsigned mirror_len = 0;
  int unsigned mirror_pos = 0;

  reply_t      expected_replies [$];
  int unsigned words_sent = 0;
  int unsigned replies_checked = 0;
  int unsigned flagged_replies = 0;
  int unsigned mismatches = 0;
  int unsigned episodes = 0;
  int unsigned op_tally [8] = '{default: 0};
  logic        no_gaps = 1'b0;

  // Directed commands: empty stream, extremes of every field, then a short loaded stream
  row_t plan [PLAN_ROWS] = '{
    '{'{OP_GET,     8'h00, 6'd8,  16'd0},      1'b1, '{32'h0,        1'b1, 16'd0}},
    '{'{OP_GET,     8'h00, 6'd0,  16'd0},      1'b1, '{32'h0,        1'b0, 16'd0}},
    '{'{OP_UE,      8'h00, 6'd0,  16'd0},      1'b1, '{32'hFFFFFFFF, 1'b1, 16'd0}},
    '{'{OP_SE,      8'h00, 6'd0,  16'd0},      1'b1, '{32'h0,        1'b1, 16'd0}},
    '{'{OP_SEEK,    8'h00, 6'd0,  16'd0},      1'b1, '{32'h0,        1'b0, 16'd0}},
    '{'{OP_SEEK,    8'h00, 6'd0,  16'd1},      1'b1, '{32'h0,        1'b1, 16'd0}},
    '{'{OP_SPARE,   8'hFF, 6'd63, 16'hFFFF},   1'b1, '{32'h0,        1'b0, 16'd0}},
    '{'{OP_LOAD,    8'hFF, 6'd0,  16'd0},      1'b1, '{32'h0,        1'b0, 16'd8}},
    '{'{OP_LOAD,    8'h00, 6'd0,  16'd0},      1'b1, '{32'h0,        1'b0, 16'd16}},
    '{'{OP_LOAD,    8'h80, 6'd0,  16'd0},      1'b1, '{32'h0,        1'b0, 16'd24}},
    '{'{OP_LOAD,    8'h5A, 6'd0,  16'd0},      1'b1, '{32'h0,        1'b0, 16'd32}},
    '{'{OP_LOAD,    8'hA5, 6'd0,  16'd0},      1'b1, '{32'h0,        1'b0, 16'd40}},
    '{'{OP_PEEK,    8'h00, 6'd32, 16'd0},      1'b1, '{32'hFF00805A, 1'b0, 16'd40}},
    '{'{OP_PEEK,    8'h00, 6'd33, 16'd0},      1'b1, '{32'h0,        1'b1, 16'd40}},
    '{'{OP_GET,     8'h00, 6'd63, 16'd0},      1'b1, '{32'h0,        1'b1, 16'd40}},
    '{'{OP_GET,     8'h00, 6'd1,  16'd0},      1'b0, '0},
    '{'{OP_UE,      8'h00, 6'd0,  16'd0},      1'b0, '0},
    '{'{OP_SEEK,    8'h00, 6'd0,  16'd8},      1'b1, '{32'h0,        1'b0, 16'd32}},
    '{'{OP_UE,      8'h00, 6'd0,  16'd0},      1'b0, '0},
    '{'{OP_SE,      8'h00, 6'd0,  16'd0},      1'b0, '0},
    '{'{OP_SEEK,    8'h00, 6'd0,  16'd40},     1'b1, '{32'h0,        1'b0, 16'd0}},
    '{'{OP_SEEK,    8'h00, 6'd0,  16'd41},     1'b1, '{32'h0,        1'b1, 16'd0}},
    '{'{OP_GET,     8'h00, 6'd32, 16'd0},      1'b1, '{32'h0,        1'b1, 16'd0}},
    '{'{OP_SEEK,    8'h00, 6'd0,  16'hFFFF},   1'b1, '{32'h0,        1'b1, 16'd0}},
    '{'{OP_RESTART, 8'h00, 6'd0,  16'd0},      1'b1, '{32'h0,        1'b0, 16'd0}}
  };

  bit_reader_exp_golomb #(
    .BUF_BYTES(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned loaded_bits();
    return mirror_len * 8;
  endfunction

  function automatic logic bit_of(int unsigned p);
    logic [7:0] b;
    b = mirror_bytes[IDX_W'(p >> 3)];
    return b[7 - (p & 7)];
  endfunction

  // MSB-first read of n bits at p; fails on a count above 32 or a read past the end
  function automatic logic take_bits(int unsigned p, int unsigned n, output logic [31:0] v);
    int unsigned i;
    v = '0;
    if (n > 32 || n > loaded_bits() - p) return 1'b0;
    for (i = 0; i < n; i++) v = {v[30:0], bit_of(p + i)};
    return 1'b1;
  endfunction

  // Exp-Golomb code number at the position; advances the position
  function automatic logic decode_code_num(output logic [31:0] k);
    int unsigned zeros, avail, lead, i;
    logic [7:0]  look;
    logic [31:0] body;
    logic        found, scanning;
    k = '1;
    zeros = 0;
    found = 1'b0;
    scanning = 1'b1;
    while (scanning) begin
      avail = loaded_bits() - mirror_pos;
      look = '0;
      for (i = 0; i < avail && i < 8; i++) look[7 - i] = bit_of(mirror_pos + i);
      if (avail >= 8 && look == 8'h00) begin
        // whole zero byte: consume it and keep scanning
        mirror_pos += 8;
        zeros += 8;
      end else begin
        scanning = 1'b0;
        if (look != 8'h00) begin
          lead = 0;
          while (!look[7 - lead]) lead++;
          mirror_pos += lead;
          zeros += lead;
          found = 1'b1;
        end
      end
    end
    // consumed zeros stay consumed on every failure below
    if (!found || zeros > 31) return 1'b0;
    if (!take_bits(mirror_pos, zeros + 1, body)) return 1'b0;
    mirror_pos += zeros + 1;
    k = body - 32'd1;
    return 1'b1;
  endfunction

  function automatic reply_t predict_reply(cmd_t c);
    reply_t      r;
    logic [31:0] k;
    r = '0;
    case (c.op)
      OP_RESTART: begin
        mirror_len = 0;
        mirror_pos = 0;
      end
      OP_LOAD: begin
        if (mirror_len < DEPTH) begin
          mirror_bytes[IDX_W'(mirror_len)] = c.data;
          mirror_len++;
        end else begin
          r.error = 1'b1;
        end
      end
      OP_GET, OP_PEEK: begin
        if (take_bits(mirror_pos, int'(c.count), k)) begin
          r.value = k;
          if (c.op == OP_GET) mirror_pos += int'(c.count);
        end else begin
          r.error = 1'b1;
        end
      end
      OP_UE: begin
        r.error = !decode_code_num(k);
        r.value = k;
      end
      OP_SE: begin
        if (decode_code_num(k)) begin
          // odd code numbers map to positive values, even ones to zero or negative
          r.value = k[0] ? ({1'b0, k[31:1]} + 32'd1) : (32'd0 - {1'b0, k[31:1]});
        end else begin
          r.error = 1'b1;
        end
      end
      OP_SEEK: begin
        if (int'(c.target) <= loaded_bits()) mirror_pos = int'(c.target);
        else r.error = 1'b1;
      end
      default: begin
      end
    endcase
    r.remaining = 16'(loaded_bits() - mirror_pos);
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] op, logic [7:0] data, logic [5:0] count,
                                    logic [15:0] target);
    cmd_t c;
    c.op = op;
    c.data = data;
    c.count = count;
    c.target = target;
    return c;
  endfunction

  // Any command but restart; seeks mostly land inside the loaded stream
  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.op = 3'($urandom_range(1, 7));
    c.data = 8'($urandom());
    c.count = 6'($urandom_range(0, 63));
    c.target = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, loaded_bits()));
    return c;
  endfunction

  // Offer one word, hold it until taken, then log what it should produce
  task automatic issue(input cmd_t c, input logic typed = 1'b0, input reply_t fixed = '0);
    reply_t want;
    while (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, c.target, c.count, c.data, c.op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = predict_reply(c);
    expected_replies.push_back(typed ? fixed : want);
    words_sent++;
    op_tally[c.op]++;
  endtask

  // Build a stream of raw fields and ue/se codes, load it, then read it back in order
  task automatic run_coded_stream();
    logic        stream_bits [$];
    cmd_t        reads [$];
    cmd_t        c;
    logic [31:0] body;
    logic [7:0]  b;
    logic        zero_pad;
    int unsigned segs, s, kind, w, lead, i, j, nbytes, passes, pass;
    segs = $urandom_range(1, 20);
    for (s = 0; s < segs; s++) begin
      kind = $urandom_range(0, 2);
      body = $urandom();
      c = '0;
      if (kind == 0) begin
        w = $urandom_range(0, 32);
        for (i = w; i > 0; i--) stream_bits.push_back(body[i - 1]);
        c.count = 6'(w);
        if ($urandom_range(9) == 0) begin
          c.op = OP_PEEK;
          reads.push_back(c);
        end
        c.op = OP_GET;
      end else begin
        // mostly short codes; some long ones, up to a prefix too long to decode
        lead = ($urandom_range(7) == 0) ? $urandom_range(13, 32) : $urandom_range(0, 12);
        repeat (lead) stream_bits.push_back(1'b0);
        stream_bits.push_back(1'b1);
        for (i = lead; i > 0; i--) stream_bits.push_back(body[i - 1]);
        c.op = (kind == 1) ? OP_UE : OP_SE;
      end
      reads.push_back(c);
    end
    // trailing zeros leave a final decode with no one bit to find
    zero_pad = $urandom_range(1);
    while (stream_bits.size() % 8 != 0) stream_bits.push_back(zero_pad ? 1'b0 : 1'($urandom()));
    if ($urandom_range(3) == 0)
      reads.push_back(make_cmd($urandom_range(1) ? OP_UE : OP_GET, 8'h00, 6'd32, 16'd0));
    nbytes = stream_bits.size() / 8;
    // now and then cut the stream short so the last reads run past the end
    if (nbytes > 0 && $urandom_range(7) == 0) nbytes -= $urandom_range(1, nbytes < 3 ? nbytes : 3);

    issue(make_cmd(OP_RESTART, 8'h00, 6'd0, 16'd0));
    for (j = 0; j < nbytes; j++) begin
      for (i = 0; i < 8; i++) b[7 - i] = stream_bits[j * 8 + i];
      issue(make_cmd(OP_LOAD, b, 6'd0, 16'd0));
    end
    passes = ($urandom_range(3) == 0) ? 2 : 1;
    for (pass = 0; pass < passes; pass++) begin
      if (pass > 0) issue(make_cmd(OP_SEEK, 8'h00, 6'd0, 16'd0));
      for (j = 0; j < reads.size(); j++) begin
        if ($urandom_range(9) == 0) issue(noise_cmd());
        issue(reads[j]);
      end
    end
  endtask

  task automatic run_coded_batch(int unsigned words);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < words) begin
      // a long stretch with no idling on either side
      no_gaps = (episodes >= 5 && episodes < 13);
      run_coded_stream();
      episodes++;
    end
    no_gaps = 1'b0;
  endtask

  task automatic check_reply(logic [55:0] word);
    reply_t want;
    if (expected_replies.size() == 0) begin
      mismatches++;
      $display("%0t: result word %h with nothing expected", $time, word);
      return;
    end
    want = expected_replies.pop_front();
    replies_checked++;
    if (word[32]) flagged_replies++;
    if (word[31:0] !== want.value) begin
      mismatches++;
      $display("%0t: value expected %h actual %h", $time, want.value, word[31:0]);
    end
    if (word[32] !== want.error) begin
      mismatches++;
      $display("%0t: error expected %b actual %b", $time, want.error, word[32]);
    end
    if (word[48:33] !== want.remaining) begin
      mismatches++;
      $display("%0t: bits_remaining expected %0d actual %0d", $time, want.remaining,
               word[48:33]);
    end
  endtask

  // Result side: check each accepted word, then decide on stalling for the next edge
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_reply(m_axis_tdata);
    m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
  end

  initial begin
    int unsigned r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < PLAN_ROWS; r++) issue(plan[r].c, plan[r].typed, plan[r].fixed);
    run_coded_batch(CODED_WORDS);
    s_axis_tvalid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("covered %0d commands over %0d coded streams: %0d get, %0d peek, %0d ue, %0d se,",
             words_sent, episodes, op_tally[OP_GET], op_tally[OP_PEEK], op_tally[OP_UE],
             op_tally[OP_SE]);
    $display("%0d seek, %0d load; %0d results checked, %0d flagged",
             op_tally[OP_SEEK], op_tally[OP_LOAD], replies_checked, flagged_replies);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", expected_replies.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/brexg_pkg.sv
rtl/brexg_store.sv
rtl/brexg_window.sv
rtl/bit_reader_exp_golomb.sv
tb/bit_reader_exp_golomb_tb.sv
